@@ hdl/smat_pkg.sv @@
// Shared types for the small matrix unit: operation codes, sequencer states and read tags.
`timescale 1ns / 1ps

package smat_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_TRN = 2'd3
    } t_op_mode;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EMIT  = 2'd1,
        ST_DRAIN = 2'd2
    } t_state;

    // Travels alongside each pair of store reads through the datapath.
    typedef struct packed {
        logic valid;
        logic first_k;
        logic last_k;
        logic last_cell;
    } t_tag;

    localparam int DataWidth = 32;

endpackage

@@ hdl/smat_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module smat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/smat_seq.sv @@
// Load counter, store write control and read address sequencer of the small matrix unit.
`timescale 1ns / 1ps

module smat_seq import smat_pkg::*; #(
    parameter int DIM = 3,
    localparam int CELLS = DIM * DIM,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int CW = $clog2(2 * CELLS + 1),
    localparam int IW = (DIM > 1) ? $clog2(DIM) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_op_mode      i_op_mode,
    input  logic          i_done,
    output logic          o_busy,
    output logic          o_a_we,
    output logic          o_b_we,
    output logic [AW-1:0] o_wr_addr,
    output logic [AW-1:0] o_a_raddr,
    output logic [AW-1:0] o_b_raddr,
    output t_tag          o_tag
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_col, n_col;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_k, n_k;

    logic          w_accept;
    logic          w_in_a;
    logic          w_in_b;
    logic [CW-1:0] w_inc;
    logic [CW-1:0] w_needed;
    logic          w_emit;
    logic          w_mul;
    logic          w_last_k;
    logic          w_last_cell;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_in_a   = r_count < CW'(CELLS);
    assign w_in_b   = !w_in_a && (r_count < CW'(2 * CELLS));
    assign w_inc    = r_count + CW'(1);
    // The mode at the time of the item decides how many elements complete a load.
    assign w_needed = (i_op_mode == OP_TRN) ? CW'(CELLS) : CW'(2 * CELLS);
    assign w_emit   = w_inc >= w_needed;

    assign w_mul       = i_op_mode == OP_MUL;
    assign w_last_k    = !w_mul || (r_k == IW'(DIM - 1));
    assign w_last_cell = w_last_k && (r_col == IW'(DIM - 1)) && (r_row == IW'(DIM - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_emit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_last_cell) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Load counter and result walk counters.
    always_comb begin
        n_count = r_count;
        n_col   = r_col;
        n_row   = r_row;
        n_k     = r_k;
        if (w_accept) begin
            n_count = w_emit ? '0 : w_inc;
        end
        if (r_state == ST_EMIT) begin
            if (!w_last_k) begin
                n_k = r_k + IW'(1);
            end else begin
                n_k = '0;
                if (r_row == IW'(DIM - 1)) begin
                    n_row = '0;
                    n_col = (r_col == IW'(DIM - 1)) ? '0 : r_col + IW'(1);
                end else begin
                    n_row = r_row + IW'(1);
                end
            end
        end
    end

    // Outputs.
    always_comb begin
        o_busy    = r_state != ST_IDLE;
        o_a_we    = w_accept && w_in_a;
        o_b_we    = w_accept && w_in_b;
        o_wr_addr = w_in_a ? AW'(r_count) : AW'(r_count - CW'(CELLS));
        unique case (i_op_mode)
            OP_MUL: begin
                o_a_raddr = AW'(r_k * DIM + r_row);
                o_b_raddr = AW'(r_col * DIM + r_k);
            end
            OP_TRN: begin
                o_a_raddr = AW'(r_row * DIM + r_col);
                o_b_raddr = AW'(r_col * DIM + r_row);
            end
            default: begin
                o_a_raddr = AW'(r_col * DIM + r_row);
                o_b_raddr = AW'(r_col * DIM + r_row);
            end
        endcase
        o_tag.valid     = r_state == ST_EMIT;
        o_tag.first_k   = !w_mul || (r_k == '0);
        o_tag.last_k    = w_last_k;
        o_tag.last_cell = w_last_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_col   <= n_col;
            r_row   <= n_row;
            r_k     <= n_k;
        end
    end

endmodule

@@ hdl/smat_dp.sv @@
// Arithmetic pipeline of the small matrix unit: element operation, accumulation and output register.
`timescale 1ns / 1ps

module smat_dp import smat_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_op_mode             i_op_mode,
    input  t_tag                 i_tag,
    input  logic [DataWidth-1:0] i_a_data,
    input  logic [DataWidth-1:0] i_b_data,
    output logic                 o_strobe,
    output logic [DataWidth-1:0] o_value,
    output logic                 o_last,
    output logic                 o_done
);

    t_tag                 r_tag1;
    t_tag                 r_tag2;
    logic [DataWidth-1:0] r_val, n_val;
    logic [DataWidth-1:0] r_acc, n_acc;
    logic                 r_out_valid;
    logic                 r_out_last;
    logic [DataWidth-1:0] r_out_value;

    always_comb begin
        unique case (i_op_mode)
            OP_ADD: n_val = i_a_data + i_b_data;
            OP_SUB: n_val = i_a_data - i_b_data;
            OP_MUL: n_val = DataWidth'(i_a_data * i_b_data);
            OP_TRN: n_val = i_a_data;
        endcase
    end

    // Only a product cell spans several terms; every other cell starts and ends on one.
    assign n_acc = (r_tag2.first_k ? '0 : r_acc) + r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1      <= '0;
            r_tag2      <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_tag1      <= i_tag;
            r_tag2      <= r_tag1;
            r_out_valid <= r_tag2.valid && r_tag2.last_k;
            r_out_last  <= r_tag2.valid && r_tag2.last_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (r_tag2.valid) begin
            r_acc <= n_acc;
            if (r_tag2.last_k) begin
                r_out_value <= n_acc;
            end
        end
    end

    assign o_strobe = r_out_valid;
    assign o_value  = r_out_value;
    assign o_last   = r_out_last;
    assign o_done   = r_tag2.valid && r_tag2.last_cell;

endmodule

@@ hdl/small_matrix_add_sub_mul_transpose.sv @@
// Top level of the small matrix unit: configuration register, two element stores, sequencer and datapath.
`timescale 1ns / 1ps

// Elements of A, then of B unless the mode is transpose, are taken one per cycle while busy is
// low, in column-major order, and written straight into two single-port-read RAMs. The item
// that completes the load raises busy, and the stores are then walked through one read port
// each: one read per result for add, subtract and transpose, DIM reads per result for the
// product, over which it is accumulated. Results are registered behind the reads at the RAM
// read, the element operation and the accumulation, and appear on o_result_value with
// o_result_strobe high for one cycle each; the receiver cannot stall and must take every
// result as it comes. busy drops in the cycle of the final result, which carries
// o_last_element. For DIM = 3 an add loads 18 elements.
// The mode register is written through the cfg channel, which is always ready, and must only
// be changed while the unit is idle.
module small_matrix_add_sub_mul_transpose import smat_pkg::*; #(
    parameter int DIM = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [DataWidth-1:0] i_element,
    output logic                        o_result_strobe,
    output logic signed [DataWidth-1:0] o_result_value,
    output logic                        o_last_element,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_data
);

    localparam int CELLS = DIM * DIM;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

    t_op_mode             r_op_mode;
    logic                 w_done;
    logic                 w_a_we;
    logic                 w_b_we;
    logic [AW-1:0]        w_wr_addr;
    logic [AW-1:0]        w_a_raddr;
    logic [AW-1:0]        w_b_raddr;
    logic [DataWidth-1:0] w_a_data;
    logic [DataWidth-1:0] w_b_data;
    logic [DataWidth-1:0] w_value;
    t_tag                 w_tag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= OP_ADD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_op_mode <= t_op_mode'(i_cfg_data);
        end
    end

    smat_seq #(
        .DIM (DIM)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_op_mode (r_op_mode),
        .i_done    (w_done),
        .o_busy    (busy),
        .o_a_we    (w_a_we),
        .o_b_we    (w_b_we),
        .o_wr_addr (w_wr_addr),
        .o_a_raddr (w_a_raddr),
        .o_b_raddr (w_b_raddr),
        .o_tag     (w_tag)
    );

    smat_ram #(
        .WIDTH (DataWidth),
        .DEPTH (CELLS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_wr_addr),
        .i_wdata (DataWidth'(i_element)),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_data)
    );

    smat_ram #(
        .WIDTH (DataWidth),
        .DEPTH (CELLS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_wr_addr),
        .i_wdata (DataWidth'(i_element)),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_data)
    );

    smat_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_mode (r_op_mode),
        .i_tag     (w_tag),
        .i_a_data  (w_a_data),
        .i_b_data  (w_b_data),
        .o_strobe  (o_result_strobe),
        .o_value   (w_value),
        .o_last    (o_last_element),
        .o_done    (w_done)
    );

    assign o_result_value = signed'(w_value);

    // The final result of a matrix is always a strobed result.
    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_element |-> o_result_strobe)
        else $error("last element flagged without a result strobe");

    // Results only come out of an emission that held busy in the cycle before.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe outside an emission");

    // A new emission cannot start producing results straight after the final one.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_element |=> !o_result_strobe)
        else $error("result strobe directly after the final element");

    // The walk and the load never write the stores at the same time.
    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !(w_a_we || w_b_we))
        else $error("store written during an emission");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the small matrix unit: directed table, random matrices, result checker.
`timescale 1ns / 1ps

module testbench;
    import smat_pkg::*;

    localparam int DIM          = 3;
    localparam int CELLS        = DIM * DIM;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 144;
    localparam int QUIET_TAIL   = 60;

    typedef struct packed {
        logic [DataWidth-1:0] value;
        logic                 last;
    } t_cell;

    // One row loads elements from two bases; a ramp adds the load position to the base.
    typedef struct packed {
        t_op_mode             mode;
        logic [4:0]           count;
        logic [DataWidth-1:0] a_base;
        logic [DataWidth-1:0] b_base;
        logic                 ramp;
        logic                 typed;
        logic [DataWidth-1:0] want;
    } t_drill_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic signed [DataWidth-1:0] i_element;
    logic                        o_result_strobe;
    logic signed [DataWidth-1:0] o_result_value;
    logic                        o_last_element;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [1:0]                  i_cfg_data;

    // Shadow of the unit: mode, both element stores and the load position.
    t_op_mode             shadow_mode;
    logic [DataWidth-1:0] a_cells [CELLS];
    logic [DataWidth-1:0] b_cells [CELLS];
    int                   fill_count;
    t_cell                due_cells [$];

    int         items_sent;
    int         cells_seen;
    int         mismatches;
    int         matrices [4];
    t_drill_row drill_rows [12];

    small_matrix_add_sub_mul_transpose #(
        .DIM(DIM)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_element      (i_element),
        .o_result_strobe(o_result_strobe),
        .o_result_value (o_result_value),
        .o_last_element (o_last_element),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stores one element and, when the load is complete, queues the whole result matrix.
    function automatic void absorb_element(input logic [DataWidth-1:0] v, input logic typed,
                                           input logic [DataWidth-1:0] want);
        int                   needed;
        int                   idx;
        logic [DataWidth-1:0] acc;
        t_cell                c;
        needed = (shadow_mode == OP_TRN) ? CELLS : 2 * CELLS;
        if (fill_count < CELLS) begin
            a_cells[fill_count] = v;
        end else if (fill_count < 2 * CELLS) begin
            b_cells[fill_count - CELLS] = v;
        end
        fill_count++;
        if (fill_count >= needed) begin
            for (int col = 0; col < DIM; col++) begin
                for (int row = 0; row < DIM; row++) begin
                    idx = col * DIM + row;
                    case (shadow_mode)
                        OP_ADD: acc = a_cells[idx] + b_cells[idx];
                        OP_SUB: acc = a_cells[idx] - b_cells[idx];
                        OP_MUL: begin
                            acc = '0;
                            for (int k = 0; k < DIM; k++) begin
                                acc = acc + a_cells[k * DIM + row] * b_cells[col * DIM + k];
                            end
                        end
                        default: acc = a_cells[row * DIM + col];
                    endcase
                    c.value = typed ? want : acc;
                    c.last  = (idx == CELLS - 1);
                    due_cells.push_back(c);
                end
            end
            matrices[shadow_mode]++;
            fill_count = 0;
        end
    endfunction

    function automatic logic [DataWidth-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4, 5:    return $urandom_range(0, 32) - 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic drive_item(input logic [DataWidth-1:0] v, input logic typed,
                              input logic [DataWidth-1:0] want);
        start     <= 1'b1;
        i_element <= v;
        do @(posedge i_clk); while (busy);
        absorb_element(v, typed, want);
        items_sent++;
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Waits until every queued result has come out, then lets the unit drain.
    task automatic wait_quiet();
        while (due_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_op_mode m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_mode = m;
    endtask

    always @(posedge i_clk) begin
        t_cell got;
        t_cell want;
        if (i_rst_n && o_result_strobe) begin
            got.value = o_result_value;
            got.last  = o_last_element;
            if (due_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result %h last %0b at %0t", got.value, got.last, $time);
                end
            end else begin
                want = due_cells.pop_front();
                cells_seen++;
                if (got.value !== want.value || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected %h last %0b, got %h last %0b",
                                 cells_seen, want.value, want.last, got.value, got.last);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        logic [DataWidth-1:0] v;
        int                   drill_items;
        int                   needed;
        int                   remaining;
        int                   count;
        logic                 bursty;
        logic                 first;
        t_drill_row           r;

        start       <= 1'b0;
        i_element   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= OP_ADD;
        i_rst_n     <= 1'b0;
        shadow_mode = OP_ADD;
        fill_count  = 0;
        items_sent  = 0;
        cells_seen  = 0;
        mismatches  = 0;
        for (int i = 0; i < CELLS; i++) begin
            a_cells[i] = '0;
            b_cells[i] = '0;
        end
        for (int i = 0; i < 4; i++) matrices[i] = 0;

        drill_rows = '{
            '{OP_ADD, 5'd18, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 32'h8000_0000},
            '{OP_SUB, 5'd18, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b1, 32'h7FFF_FFFF},
            '{OP_MUL, 5'd18, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0003},
            '{OP_TRN, 5'd9,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
            '{OP_ADD, 5'd18, 32'h7FFF_FFFC, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_MUL, 5'd18, 32'h0001_0000, 32'hFFFF_0003, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_TRN, 5'd9,  32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
            // A complete, then part of B, with no result yet.
            '{OP_ADD, 5'd12, 32'h1234_5678, 32'h0000_000F, 1'b0, 1'b0, 32'h0000_0000},
            // Switching to transpose part-way through B emits the transpose of A at once.
            '{OP_TRN, 5'd1,  32'h0000_0000, 32'hBBBB_BBBB, 1'b0, 1'b1, 32'h1234_5678},
            // Leaving transpose part-way through A carries the load on through B.
            '{OP_TRN, 5'd5,  32'h0000_0100, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_MUL, 5'd13, 32'hFFFF_FFF0, 32'h7FFF_0000, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_SUB, 5'd18, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (drill_rows[n]) begin
            r = drill_rows[n];
            start <= 1'b0;
            wait_quiet();
            write_mode(r.mode);
            for (int i = 0; i < r.count; i++) begin
                if (fill_count < CELLS) begin
                    v = r.a_base + (r.ramp ? fill_count : 0);
                end else begin
                    v = r.b_base + (r.ramp ? fill_count - CELLS : 0);
                end
                drive_item(v, r.typed, r.want);
            end
        end
        drill_items = items_sent;

        first = 1'b1;
        while (items_sent < drill_items + RANDOM_ITEMS) begin
            // Only some matrices change the mode; the others queue up behind the busy unit.
            if (first || $urandom_range(0, 1) == 0) begin
                start <= 1'b0;
                wait_quiet();
                write_mode(t_op_mode'($urandom_range(0, 3)));
                first = 1'b0;
            end
            needed    = (shadow_mode == OP_TRN) ? CELLS : 2 * CELLS;
            remaining = (fill_count >= needed) ? 1 : needed - fill_count;
            count     = ($urandom_range(0, 7) == 0) ? $urandom_range(1, remaining) : remaining;
            bursty    = (items_sent < drill_items + RANDOM_ITEMS - QUIET_TAIL)
                        && ($urandom_range(0, 3) != 0);
            repeat (count) begin
                if (bursty && $urandom_range(0, 2) == 0) begin
                    pause($urandom_range(1, 14));
                end
                drive_item(pick_element(), 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (due_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d elements and %0d result cells, %0d mismatches",
                 items_sent, cells_seen, mismatches);
        $display("matrices emitted: add %0d, subtract %0d, multiply %0d, transpose %0d",
                 matrices[OP_ADD], matrices[OP_SUB], matrices[OP_MUL], matrices[OP_TRN]);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
